// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file spq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables the check.
`define SPQ_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error(msg);

// Same check on the default clk and arst_n of the enclosing scope.
`define SPQ_CHECK(lbl, prop, msg) \
	`SPQ_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// File: hw/rtl/spq_pkg.sv
// Types, constants and helper functions of the stable priority queue.
package spq_pkg;

	localparam int CAPACITY      = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int VALUE_W       = 32;
	localparam int PORT_PRIO_W   = 8;
	localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int PRIO_EXT_W    = (PRIORITY_BITS > PORT_PRIO_W) ? PRIORITY_BITS : PORT_PRIO_W;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [PRIORITY_BITS-1:0] prio_t;
	typedef logic [VALUE_W-1:0]       value_t;

	typedef struct packed {
		value_t value;
		prio_t  prio;
	} entry_t;

	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		idx_t   raddr;
	} store_req_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_REMOVED   = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_REM_RD,
		S_REM_DATA,
		S_RESP
	} state_t;

	// Circular index: base plus offset, wrapped at CAPACITY.
	function automatic idx_t wrap_add(idx_t base, cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic prio_t req_to_prio(logic [PORT_PRIO_W-1:0] p);
		logic [PRIO_EXT_W-1:0] ext;
		ext = PRIO_EXT_W'(p);
		return ext[PRIORITY_BITS-1:0];
	endfunction

	function automatic logic [PORT_PRIO_W-1:0] prio_to_port(prio_t p);
		logic [PRIO_EXT_W-1:0] ext;
		ext = PRIO_EXT_W'(p);
		return ext[PORT_PRIO_W-1:0];
	endfunction

endpackage

// File: hw/rtl/spq_if.sv
// Request and response channel interfaces of the priority queue.
interface spq_req_if;
	import spq_pkg::*;
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic signed [VALUE_W-1:0]      item_value;
	logic        [PORT_PRIO_W-1:0]  priority_req;

	modport source(output valid, operation, item_value, priority_req, input ready);
	modport sink(input valid, operation, item_value, priority_req, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic                           valid;
	logic                           ready;
	logic        [1:0]              status;
	logic signed [VALUE_W-1:0]      removed_value;
	logic        [PORT_PRIO_W-1:0]  removed_priority;

	modport source(output valid, status, removed_value, removed_priority, input ready);
	modport sink(input valid, status, removed_value, removed_priority, output ready);
endinterface

// File: hw/rtl/spq_store.sv
// Entry store: one write port, one read port with registered read data.
module spq_store (
	input  logic               clk,
	input  spq_pkg::store_req_t req,
	output spq_pkg::entry_t    rd_entry
);
	import spq_pkg::*;

	entry_t mem [CAPACITY];
	entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_entry_q <= mem[req.raddr];
	end

	assign rd_entry = rd_entry_q;

endmodule

// File: hw/rtl/spq_ctrl.sv
// Sequencer with the priority comparator and the response register.
module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	spq_req_if.sink             req,
	spq_rsp_if.source           rsp,
	output spq_pkg::store_req_t store_req,
	input  spq_pkg::entry_t     rd_entry
);
	import spq_pkg::*;

	state_t                  state_q, state_d;
	idx_t                    head_q;
	cnt_t                    count_q;
	cnt_t                    idx_q;
	value_t                  value_q;
	prio_t                   prio_q;
	status_t                 res_status_q;
	value_t                  res_value_q;
	logic [PORT_PRIO_W-1:0]  res_prio_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	value_t                  out_value_q;
	logic [PORT_PRIO_W-1:0]  out_prio_q;

	logic accept;
	logic full;
	logic empty;
	logic shift_up;
	logic load_out;
	op_t  req_op;

	assign req_op   = op_t'(req.operation);
	assign accept   = req.valid && req.ready;
	assign full     = (count_q == cnt_t'(CAPACITY));
	assign empty    = (count_q == '0);
	// Stored entry ranks strictly behind the new one: move it up a slot.
	assign shift_up = (rd_entry.prio > prio_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req_op == OP_INSERT) begin
						state_d = full ? S_RESP : S_INS_RD;
					end else begin
						state_d = empty ? S_RESP : S_REM_RD;
					end
				end
			end
			S_INS_RD: begin
				state_d = (idx_q == '0) ? S_RESP : S_INS_CMP;
			end
			S_INS_CMP: begin
				state_d = shift_up ? S_INS_RD : S_RESP;
			end
			S_REM_RD: begin
				state_d = S_REM_DATA;
			end
			S_REM_DATA: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		req.ready       = (state_q == S_IDLE);
		load_out        = 1'b0;
		store_req.we    = 1'b0;
		store_req.waddr = wrap_add(head_q, idx_q);
		store_req.wdata = '{value: value_q, prio: prio_q};
		store_req.raddr = wrap_add(head_q, idx_q - cnt_t'(1));
		case (state_q)
			S_INS_RD: begin
				if (idx_q == '0) begin
					store_req.we = 1'b1;
				end
			end
			S_INS_CMP: begin
				store_req.we = 1'b1;
				if (shift_up) begin
					store_req.wdata = rd_entry;
				end
			end
			S_REM_RD: begin
				store_req.raddr = head_q;
			end
			S_RESP: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_INS_RD && idx_q == '0) || (state_q == S_INS_CMP && !shift_up)) begin
				count_q <= count_q + cnt_t'(1);
			end
			if (state_q == S_REM_DATA) begin
				head_q  <= wrap_add(head_q, cnt_t'(1));
				count_q <= count_q - cnt_t'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction payload and walk index
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q     <= value_t'(req.item_value);
			prio_q      <= req_to_prio(req.priority_req);
			idx_q       <= count_q;
			res_value_q <= '0;
			res_prio_q  <= '0;
			if (req_op == OP_INSERT) begin
				res_status_q <= full ? ST_OVERFLOW : ST_INSERTED;
			end else begin
				res_status_q <= empty ? ST_UNDERFLOW : ST_REMOVED;
			end
		end
		if (state_q == S_INS_CMP && shift_up) begin
			idx_q <= idx_q - cnt_t'(1);
		end
		if (state_q == S_REM_DATA) begin
			res_value_q <= rd_entry.value;
			res_prio_q  <= prio_to_port(rd_entry.prio);
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_prio_q   <= res_prio_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_status_q;
	assign rsp.removed_value    = out_value_q;
	assign rsp.removed_priority = out_prio_q;

endmodule

// File: hw/rtl/stable_priority_queue_unit.sv
// Top level: insert walks back from the tail, one entry at a time
// (S_INS_RD reads the store, then S_INS_CMP compares and writes). The
// walk moves at most count entries and stops at index zero or on a compare;
// remove passes S_REM_RD and S_REM_DATA, overflow and underflow go to S_RESP.
// A new transaction is taken while the previous response waits to be taken.
// Reset clears the queue to empty; the store holds no reset and needs no clearing.
module stable_priority_queue_unit (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	store_req_t store_req;
	entry_t     rd_entry;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.store_req (store_req),
		.rd_entry  (rd_entry)
	);

	spq_store u_store (
		.clk      (clk),
		.req      (store_req),
		.rd_entry (rd_entry)
	);

endmodule

// File: hw/rtl/spq_checker.sv
// Port-level checker for the priority queue, bound to the top level.
`include "assert_macros.svh"

module spq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status
);
	import spq_pkg::*;

	logic [1:0] pend_q;
	cnt_t       occ_q;
	logic       req_fire;
	logic       rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// Track transactions in flight and queue occupancy seen from responses.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			occ_q  <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_fire) - 2'(rsp_fire);
			if (rsp_fire && rsp_status == ST_INSERTED) begin
				occ_q <= occ_q + cnt_t'(1);
			end else if (rsp_fire && rsp_status == ST_REMOVED) begin
				occ_q <= occ_q - cnt_t'(1);
			end
		end
	end

	`SPQ_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "response dropped or changed while stalled")
	`SPQ_CHECK(a_pending, (pend_q <= 2'd2) && (!rsp_valid || pend_q != 2'd0), "response without transaction or too many in flight")
	`SPQ_CHECK(a_underflow, rsp_valid && rsp_status == ST_UNDERFLOW |-> occ_q == '0, "underflow reported on a non-empty queue")
	`SPQ_CHECK(a_overflow, rsp_valid && rsp_status == ST_OVERFLOW |-> occ_q == cnt_t'(CAPACITY), "overflow reported on a queue that is not full")

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status)
);
